>>> src/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants and codes for the segment to segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int DIST_W              = 17;
  localparam int CASE_W              = 2;
  localparam int CFG_W               = 16;

  typedef enum logic [CASE_W-1:0] {
    CASE_GENERAL      = 2'd0,
    CASE_BOTH_POINTS  = 2'd1,
    CASE_FIRST_POINT  = 2'd2,
    CASE_SECOND_POINT = 2'd3
  } case_t;

  // Source of a line parameter once the second division is done.
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_KEEP,
    SEL_QUOT
  } sel_t;

endpackage

>>> src/segment_segment_distance.sv
// ----------------------------------------------------------------------------
// segment_segment_distance
// Shortest distance between two 3D segments, fully pipelined closest-point
// method with two pipelined fractional dividers and a pipelined square root.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-------------------------
//   input   | start, busy, in_*                      | start && !busy
//   result  | out_valid, out_distance, out_case_taken| out_valid, one cycle
//   config  | cfg_valid, cfg_ready, cfg_point_thresh.| cfg_valid && cfg_ready
//
// One item enters every cycle; busy is always low.
// Each divider produces one quotient bit per stage and the square root
// one result bit per stage. Reset clears the valid bits and the threshold
// register. The pipeline never stalls, as it has no back-pressure; the
// receiver must take every result, which the block does not enforce.
// ----------------------------------------------------------------------------
module segment_segment_distance #(
  parameter int COORD_WIDTH     = ssd_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      in_first_start_x,
  input  logic signed [COORD_WIDTH-1:0]      in_first_start_y,
  input  logic signed [COORD_WIDTH-1:0]      in_first_start_z,
  input  logic signed [COORD_WIDTH-1:0]      in_first_end_x,
  input  logic signed [COORD_WIDTH-1:0]      in_first_end_y,
  input  logic signed [COORD_WIDTH-1:0]      in_first_end_z,
  input  logic signed [COORD_WIDTH-1:0]      in_second_start_x,
  input  logic signed [COORD_WIDTH-1:0]      in_second_start_y,
  input  logic signed [COORD_WIDTH-1:0]      in_second_start_z,
  input  logic signed [COORD_WIDTH-1:0]      in_second_end_x,
  input  logic signed [COORD_WIDTH-1:0]      in_second_end_y,
  input  logic signed [COORD_WIDTH-1:0]      in_second_end_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssd_pkg::CFG_W-1:0]          cfg_point_threshold,
  output logic                               out_valid,
  output logic [ssd_pkg::DIST_W-1:0]         out_distance,
  output logic [ssd_pkg::CASE_W-1:0]         out_case_taken
);

  localparam int CW     = COORD_WIDTH;
  localparam int FB     = PARAM_FRAC_BITS;
  localparam int DIF_W  = CW + 1;
  localparam int GEO_W  = 9 * DIF_W;
  localparam int PRD_W  = 2 * DIF_W;
  localparam int DOT_W  = PRD_W + 2;
  localparam int WP_W   = 2 * DOT_W;
  localparam int NA     = WP_W + 1;
  localparam int S_W    = FB + 1;
  localparam int BS_W   = DOT_W + S_W + 1;
  localparam int NB     = BS_W + 1;
  localparam int PD_W   = DIF_W + S_W + 1;
  localparam int GC_W   = PD_W + 1;
  localparam int G_W    = CW + FB + 2;
  localparam int SQ_W   = 2 * G_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RT_IN  = SUM_W - 2 * FB;
  localparam int RT_W   = RT_IN / 2;
  localparam int LAT    = 2 * FB + 14 + RT_W;
  localparam int IA     = 0;
  localparam int IE     = 1;
  localparam int IB     = 2;
  localparam int IC     = 3;
  localparam int IF     = 4;
  localparam logic [S_W-1:0] ONE = {1'b1, {FB{1'b0}}};

  logic [ssd_pkg::CFG_W-1:0] thr_r;
  logic signed [CW-1:0]      p1 [3];
  logic signed [CW-1:0]      q1 [3];
  logic signed [CW-1:0]      p2 [3];
  logic signed [CW-1:0]      q2 [3];

  // Stage 1: differences.
  logic             v1_r;
  logic [GEO_W-1:0] geo_nxt;
  logic [GEO_W-1:0] geo1_r;
  // Stage 2: products.
  logic                    v2_r;
  logic signed [PRD_W-1:0] prd_nxt [15];
  logic signed [PRD_W-1:0] prd2_r [15];
  logic [GEO_W-1:0]        geo2_r;
  // Stage 3: dot products.
  logic                    v3_r;
  logic signed [DOT_W-1:0] dot_nxt [5];
  logic signed [DOT_W-1:0] dot3_r [5];
  logic [GEO_W-1:0]        geo3_r;
  // Stage 4: case and wide products.
  logic                    v4_r;
  logic                    a_pt;
  logic                    e_pt;
  ssd_pkg::case_t          kind_nxt;
  ssd_pkg::case_t          kind4_r;
  logic signed [DOT_W-1:0] dot4_r [5];
  logic [GEO_W-1:0]        geo4_r;
  logic signed [WP_W-1:0]  ae4_r;
  logic signed [WP_W-1:0]  bb4_r;
  logic signed [WP_W-1:0]  bf4_r;
  logic signed [WP_W-1:0]  ce4_r;
  logic signed [NA-1:0]    denom;
  logic signed [NA-1:0]    snum;
  // First divider.
  logic                    va_r    [0:FB];
  logic [NA-1:0]           rema_r  [0:FB];
  logic [NA-1:0]           dena_r  [0:FB];
  logic [FB-1:0]           qa_r    [0:FB];
  logic                    zeroa_r [0:FB];
  logic                    fulla_r [0:FB];
  logic signed [DOT_W-1:0] dota_r  [0:FB][5];
  logic [GEO_W-1:0]        geoa_r  [0:FB];
  ssd_pkg::case_t          kinda_r [0:FB];
  logic [S_W-1:0]          s0;
  // Stage 6: b times s.
  logic                    v6_r;
  logic signed [BS_W-1:0]  bs6_r;
  logic [S_W-1:0]          s06_r;
  logic signed [DOT_W-1:0] dot6_r [5];
  logic [GEO_W-1:0]        geo6_r;
  ssd_pkg::case_t          kind6_r;
  // Stage 7: tn.
  logic                    v7_r;
  logic signed [NB-1:0]    tn7_r;
  logic [S_W-1:0]          s07_r;
  logic signed [DOT_W-1:0] dot7_r [5];
  logic [GEO_W-1:0]        geo7_r;
  ssd_pkg::case_t          kind7_r;
  // Stage 8: branch selection.
  logic                    v8_r;
  logic signed [NB-1:0]    esc;
  logic signed [NB-1:0]    ext_f;
  logic signed [NB-1:0]    ext_e;
  logic signed [NB-1:0]    ext_a;
  logic signed [NB-1:0]    negc;
  logic signed [NB-1:0]    bmc;
  logic signed [NB-1:0]    numb_nxt;
  logic signed [NB-1:0]    denb_nxt;
  ssd_pkg::sel_t           ssel_nxt;
  ssd_pkg::sel_t           tsel_nxt;
  logic signed [NB-1:0]    numb8_r;
  logic signed [NB-1:0]    denb8_r;
  ssd_pkg::sel_t           ssel8_r;
  ssd_pkg::sel_t           tsel8_r;
  logic [S_W-1:0]          s08_r;
  logic [GEO_W-1:0]        geo8_r;
  ssd_pkg::case_t          kind8_r;
  // Second divider.
  logic                    vb_r    [0:FB];
  logic [NB-1:0]           remb_r  [0:FB];
  logic [NB-1:0]           denb_r  [0:FB];
  logic [FB-1:0]           qb_r    [0:FB];
  logic                    zerob_r [0:FB];
  logic                    fullb_r [0:FB];
  ssd_pkg::sel_t           sselb_r [0:FB];
  ssd_pkg::sel_t           tselb_r [0:FB];
  logic [S_W-1:0]          s0b_r   [0:FB];
  logic [GEO_W-1:0]        geob_r  [0:FB];
  ssd_pkg::case_t          kindb_r [0:FB];
  logic [S_W-1:0]          quot;
  // Stage 9: s and t.
  logic                    v9_r;
  logic [S_W-1:0]          s_nxt;
  logic [S_W-1:0]          t_nxt;
  logic [S_W-1:0]          s9_r;
  logic [S_W-1:0]          t9_r;
  logic [GEO_W-1:0]        geo9_r;
  ssd_pkg::case_t          kind9_r;
  // Stage 10 to 12: gap vector and squares.
  logic                    v10_r;
  logic signed [PD_W-1:0]  ds1_r [3];
  logic signed [PD_W-1:0]  ds2_r [3];
  logic [GEO_W-1:0]        geo10_r;
  ssd_pkg::case_t          kind10_r;
  logic                    v11_r;
  logic signed [GC_W-1:0]  gc [3];
  logic signed [G_W-1:0]   g11_r [3];
  ssd_pkg::case_t          kind11_r;
  logic                    v12_r;
  logic signed [SQ_W-1:0]  sq12_r [3];
  ssd_pkg::case_t          kind12_r;
  logic [SUM_W-1:0]        sum;
  // Square root.
  logic                    vs_r    [0:RT_W];
  logic [RT_IN-1:0]        xs_r    [0:RT_W];
  logic [RT_W+1:0]         rems_r  [0:RT_W];
  logic [RT_W-1:0]         roots_r [0:RT_W];
  ssd_pkg::case_t          kinds_r [0:RT_W];
  logic [RT_W+ssd_pkg::DIST_W-1:0] root_ext;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_point_threshold;
    end
  end

  assign p1[0] = in_first_start_x;
  assign p1[1] = in_first_start_y;
  assign p1[2] = in_first_start_z;
  assign q1[0] = in_first_end_x;
  assign q1[1] = in_first_end_y;
  assign q1[2] = in_first_end_z;
  assign p2[0] = in_second_start_x;
  assign p2[1] = in_second_start_y;
  assign p2[2] = in_second_start_z;
  assign q2[0] = in_second_end_x;
  assign q2[1] = in_second_end_y;
  assign q2[2] = in_second_end_z;

  // Valid bits of the fixed stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else begin
      v1_r  <= start && !busy;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v6_r  <= va_r[FB];
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= vb_r[FB];
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  // Stage 1: d1 = Q1 - P1, d2 = Q2 - P2, r = P1 - P2.
  always_comb begin
    geo_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      geo_nxt[k*DIF_W +: DIF_W]     = {q1[k][CW-1], q1[k]} - {p1[k][CW-1], p1[k]};
      geo_nxt[(3+k)*DIF_W +: DIF_W] = {q2[k][CW-1], q2[k]} - {p2[k][CW-1], p2[k]};
      geo_nxt[(6+k)*DIF_W +: DIF_W] = {p1[k][CW-1], p1[k]} - {p2[k][CW-1], p2[k]};
    end
  end

  always_ff @(posedge clk) begin
    geo1_r <= geo_nxt;
  end

  // Stage 2: the fifteen component products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prd_nxt[k]    = $signed(geo1_r[k*DIF_W +: DIF_W]) * $signed(geo1_r[k*DIF_W +: DIF_W]);
      prd_nxt[3+k]  = $signed(geo1_r[(3+k)*DIF_W +: DIF_W])
                    * $signed(geo1_r[(3+k)*DIF_W +: DIF_W]);
      prd_nxt[6+k]  = $signed(geo1_r[k*DIF_W +: DIF_W])
                    * $signed(geo1_r[(3+k)*DIF_W +: DIF_W]);
      prd_nxt[9+k]  = $signed(geo1_r[k*DIF_W +: DIF_W])
                    * $signed(geo1_r[(6+k)*DIF_W +: DIF_W]);
      prd_nxt[12+k] = $signed(geo1_r[(3+k)*DIF_W +: DIF_W])
                    * $signed(geo1_r[(6+k)*DIF_W +: DIF_W]);
    end
  end

  always_ff @(posedge clk) begin
    prd2_r <= prd_nxt;
    geo2_r <= geo1_r;
  end

  // Stage 3: a, e, b, c and f.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dot_nxt[j] = {{2{prd2_r[3*j][PRD_W-1]}}, prd2_r[3*j]}
                 + {{2{prd2_r[3*j+1][PRD_W-1]}}, prd2_r[3*j+1]}
                 + {{2{prd2_r[3*j+2][PRD_W-1]}}, prd2_r[3*j+2]};
    end
  end

  always_ff @(posedge clk) begin
    dot3_r <= dot_nxt;
    geo3_r <= geo2_r;
  end

  // Stage 4: degenerate cases and the wide products of the general case.
  assign a_pt = dot3_r[IA] <= $signed({{(DOT_W-ssd_pkg::CFG_W){1'b0}}, thr_r});
  assign e_pt = dot3_r[IE] <= $signed({{(DOT_W-ssd_pkg::CFG_W){1'b0}}, thr_r});

  always_comb begin
    if (a_pt && e_pt) begin
      kind_nxt = ssd_pkg::CASE_BOTH_POINTS;
    end else if (a_pt) begin
      kind_nxt = ssd_pkg::CASE_FIRST_POINT;
    end else if (e_pt) begin
      kind_nxt = ssd_pkg::CASE_SECOND_POINT;
    end else begin
      kind_nxt = ssd_pkg::CASE_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    kind4_r <= kind_nxt;
    dot4_r  <= dot3_r;
    geo4_r  <= geo3_r;
    ae4_r   <= dot3_r[IA] * dot3_r[IE];
    bb4_r   <= dot3_r[IB] * dot3_r[IB];
    bf4_r   <= dot3_r[IB] * dot3_r[IF];
    ce4_r   <= dot3_r[IC] * dot3_r[IE];
  end

  assign denom = {ae4_r[WP_W-1], ae4_r} - {bb4_r[WP_W-1], bb4_r};
  assign snum  = {bf4_r[WP_W-1], bf4_r} - {ce4_r[WP_W-1], ce4_r};

  // First divider: s = clamp(snum / denom), one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r[0] <= 1'b0;
    end else begin
      va_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    rema_r[0]  <= snum;
    dena_r[0]  <= denom;
    qa_r[0]    <= '0;
    zeroa_r[0] <= (denom <= 0) || (snum <= 0);
    fulla_r[0] <= (denom > 0) && (snum > 0) && (snum >= denom);
    dota_r[0]  <= dot4_r;
    geoa_r[0]  <= geo4_r;
    kinda_r[0] <= kind4_r;
  end

  for (genvar j = 1; j <= FB; j++) begin : g_diva
    logic [NA-1:0] shl;
    logic          ge;
    assign shl = {rema_r[j-1][NA-2:0], 1'b0};
    assign ge  = shl >= dena_r[j-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[j] <= 1'b0;
      end else begin
        va_r[j] <= va_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rema_r[j]  <= ge ? shl - dena_r[j-1] : shl;
      dena_r[j]  <= dena_r[j-1];
      qa_r[j]    <= {qa_r[j-1][FB-2:0], ge};
      zeroa_r[j] <= zeroa_r[j-1];
      fulla_r[j] <= fulla_r[j-1];
      dota_r[j]  <= dota_r[j-1];
      geoa_r[j]  <= geoa_r[j-1];
      kinda_r[j] <= kinda_r[j-1];
    end
  end

  always_comb begin
    if (zeroa_r[FB]) begin
      s0 = '0;
    end else if (fulla_r[FB]) begin
      s0 = ONE;
    end else begin
      s0 = {1'b0, qa_r[FB]};
    end
  end

  // Stage 6 and 7: tn = b*s + f*one.
  always_ff @(posedge clk) begin
    bs6_r   <= dota_r[FB][IB] * $signed({1'b0, s0});
    s06_r   <= s0;
    dot6_r  <= dota_r[FB];
    geo6_r  <= geoa_r[FB];
    kind6_r <= kinda_r[FB];
  end

  always_ff @(posedge clk) begin
    tn7_r   <= {bs6_r[BS_W-1], bs6_r}
             + {{3{dot6_r[IF][DOT_W-1]}}, dot6_r[IF], {FB{1'b0}}};
    s07_r   <= s06_r;
    dot7_r  <= dot6_r;
    geo7_r  <= geo6_r;
    kind7_r <= kind6_r;
  end

  // Stage 8: choose the second quotient and where s and t come from.
  assign esc   = {3'b000, dot7_r[IE], {FB{1'b0}}};
  assign ext_f = {{(NB-DOT_W){dot7_r[IF][DOT_W-1]}}, dot7_r[IF]};
  assign ext_e = {{(NB-DOT_W){dot7_r[IE][DOT_W-1]}}, dot7_r[IE]};
  assign ext_a = {{(NB-DOT_W){dot7_r[IA][DOT_W-1]}}, dot7_r[IA]};
  assign negc  = -{{(NB-DOT_W){dot7_r[IC][DOT_W-1]}}, dot7_r[IC]};
  assign bmc   = {{(NB-DOT_W){dot7_r[IB][DOT_W-1]}}, dot7_r[IB]} + negc;

  always_comb begin
    numb_nxt = '0;
    denb_nxt = '0;
    ssel_nxt = ssd_pkg::SEL_ZERO;
    tsel_nxt = ssd_pkg::SEL_ZERO;
    case (kind7_r)
      ssd_pkg::CASE_BOTH_POINTS: begin
        ssel_nxt = ssd_pkg::SEL_ZERO;
        tsel_nxt = ssd_pkg::SEL_ZERO;
      end
      ssd_pkg::CASE_FIRST_POINT: begin
        tsel_nxt = ssd_pkg::SEL_QUOT;
        numb_nxt = ext_f;
        denb_nxt = ext_e;
      end
      ssd_pkg::CASE_SECOND_POINT: begin
        ssel_nxt = ssd_pkg::SEL_QUOT;
        numb_nxt = negc;
        denb_nxt = ext_a;
      end
      ssd_pkg::CASE_GENERAL: begin
        if (tn7_r < 0) begin
          ssel_nxt = ssd_pkg::SEL_QUOT;
          numb_nxt = negc;
          denb_nxt = ext_a;
        end else if (tn7_r > esc) begin
          ssel_nxt = ssd_pkg::SEL_QUOT;
          tsel_nxt = ssd_pkg::SEL_ONE;
          numb_nxt = bmc;
          denb_nxt = ext_a;
        end else begin
          ssel_nxt = ssd_pkg::SEL_KEEP;
          tsel_nxt = ssd_pkg::SEL_QUOT;
          numb_nxt = tn7_r;
          denb_nxt = esc;
        end
      end
      default: begin
        ssel_nxt = ssd_pkg::SEL_ZERO;
        tsel_nxt = ssd_pkg::SEL_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    numb8_r <= numb_nxt;
    denb8_r <= denb_nxt;
    ssel8_r <= ssel_nxt;
    tsel8_r <= tsel_nxt;
    s08_r   <= s07_r;
    geo8_r  <= geo7_r;
    kind8_r <= kind7_r;
  end

  // Second divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r[0] <= 1'b0;
    end else begin
      vb_r[0] <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    remb_r[0]  <= numb8_r;
    denb_r[0]  <= denb8_r;
    qb_r[0]    <= '0;
    zerob_r[0] <= (denb8_r <= 0) || (numb8_r <= 0);
    fullb_r[0] <= (denb8_r > 0) && (numb8_r > 0) && (numb8_r >= denb8_r);
    sselb_r[0] <= ssel8_r;
    tselb_r[0] <= tsel8_r;
    s0b_r[0]   <= s08_r;
    geob_r[0]  <= geo8_r;
    kindb_r[0] <= kind8_r;
  end

  for (genvar j = 1; j <= FB; j++) begin : g_divb
    logic [NB-1:0] shl;
    logic          ge;
    assign shl = {remb_r[j-1][NB-2:0], 1'b0};
    assign ge  = shl >= denb_r[j-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vb_r[j] <= 1'b0;
      end else begin
        vb_r[j] <= vb_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      remb_r[j]  <= ge ? shl - denb_r[j-1] : shl;
      denb_r[j]  <= denb_r[j-1];
      qb_r[j]    <= {qb_r[j-1][FB-2:0], ge};
      zerob_r[j] <= zerob_r[j-1];
      fullb_r[j] <= fullb_r[j-1];
      sselb_r[j] <= sselb_r[j-1];
      tselb_r[j] <= tselb_r[j-1];
      s0b_r[j]   <= s0b_r[j-1];
      geob_r[j]  <= geob_r[j-1];
      kindb_r[j] <= kindb_r[j-1];
    end
  end

  always_comb begin
    if (zerob_r[FB]) begin
      quot = '0;
    end else if (fullb_r[FB]) begin
      quot = ONE;
    end else begin
      quot = {1'b0, qb_r[FB]};
    end
  end

  // Stage 9: final s and t.
  always_comb begin
    case (sselb_r[FB])
      ssd_pkg::SEL_ZERO: s_nxt = '0;
      ssd_pkg::SEL_ONE:  s_nxt = ONE;
      ssd_pkg::SEL_KEEP: s_nxt = s0b_r[FB];
      ssd_pkg::SEL_QUOT: s_nxt = quot;
      default:           s_nxt = '0;
    endcase
    case (tselb_r[FB])
      ssd_pkg::SEL_ZERO: t_nxt = '0;
      ssd_pkg::SEL_ONE:  t_nxt = ONE;
      ssd_pkg::SEL_KEEP: t_nxt = s0b_r[FB];
      ssd_pkg::SEL_QUOT: t_nxt = quot;
      default:           t_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s9_r    <= s_nxt;
    t9_r    <= t_nxt;
    geo9_r  <= geob_r[FB];
    kind9_r <= kindb_r[FB];
  end

  // Stages 10 to 12: gap between the closest points and its squares.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ds1_r[k] <= $signed(geo9_r[k*DIF_W +: DIF_W]) * $signed({1'b0, s9_r});
      ds2_r[k] <= $signed(geo9_r[(3+k)*DIF_W +: DIF_W]) * $signed({1'b0, t9_r});
    end
    geo10_r  <= geo9_r;
    kind10_r <= kind9_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gc[k] = {{3{geo10_r[(7+k)*DIF_W-1]}}, geo10_r[(6+k)*DIF_W +: DIF_W], {FB{1'b0}}}
            + {ds1_r[k][PD_W-1], ds1_r[k]} - {ds2_r[k][PD_W-1], ds2_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      g11_r[k]  <= gc[k][G_W-1:0];
      sq12_r[k] <= g11_r[k] * g11_r[k];
    end
    kind11_r <= kind10_r;
    kind12_r <= kind11_r;
  end

  assign sum = {2'b00, sq12_r[0]} + {2'b00, sq12_r[1]} + {2'b00, sq12_r[2]};

  // Square root, one result bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else begin
      vs_r[0] <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    xs_r[0]    <= sum[SUM_W-1:2*FB];
    rems_r[0]  <= '0;
    roots_r[0] <= '0;
    kinds_r[0] <= kind12_r;
  end

  for (genvar j = 1; j <= RT_W; j++) begin : g_sqrt
    logic [RT_W+1:0] rem2;
    logic [RT_W+1:0] trial;
    logic            ge;
    assign rem2  = {rems_r[j-1][RT_W-1:0], xs_r[j-1][RT_IN-1 -: 2]};
    assign trial = {roots_r[j-1], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j] <= 1'b0;
      end else begin
        vs_r[j] <= vs_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      xs_r[j]    <= {xs_r[j-1][RT_IN-3:0], 2'b00};
      rems_r[j]  <= ge ? rem2 - trial : rem2;
      roots_r[j] <= {roots_r[j-1][RT_W-2:0], ge};
      kinds_r[j] <= kinds_r[j-1];
    end
  end

  assign root_ext       = {{ssd_pkg::DIST_W{1'b0}}, roots_r[RT_W]};
  assign out_valid      = vs_r[RT_W];
  assign out_distance   = root_ext[ssd_pkg::DIST_W-1:0];
  assign out_case_taken = kinds_r[RT_W];

  a_latency : assert property (@(posedge clk)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item accepted at the pipeline depth");

  a_st_range : assert property (@(posedge clk) disable iff (!rst_n)
    v9_r |-> (s9_r <= ONE) && (t9_r <= ONE))
    else $error("line parameter above one");

  a_points_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (v9_r && (kind9_r == ssd_pkg::CASE_BOTH_POINTS)) |-> (s9_r == '0) && (t9_r == '0))
    else $error("both segments are points but a parameter is non-zero");

endmodule
